[hw/rtl/sha256_message_hasher_defines.svh]
// Assertion macros used by the checker file.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// Assert that a condition implies a consequence in the following cycle.
`define SHA_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

[hw/rtl/sha_pkg.sv]
// Constants and round functions for the SHA-256 hasher.
package sha_pkg;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam int unsigned DigestWords = 8;
   localparam int unsigned Rounds     = 64;
   localparam logic [7:0]  PadByte    = 8'h80;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type a, b, c, d, e, f, g, h;
   } work_type;

   // req beat: one message byte and its flags
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_payload_type;

   // rsp beat: one digest word
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   function automatic word_type rotr(word_type v, int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type small_sig0(word_type x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(word_type x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic work_type round_step(work_type s, word_type k, word_type w);
      word_type t1, t2;
      work_type r;
      t1 = s.h + (rotr(s.e, 6) ^ rotr(s.e, 11) ^ rotr(s.e, 25))
         + ((s.e & s.f) ^ (~s.e & s.g)) + k + w;
      t2 = (rotr(s.a, 2) ^ rotr(s.a, 13) ^ rotr(s.a, 22))
         + ((s.a & s.b) ^ (s.a & s.c) ^ (s.b & s.c));
      r.h = s.g; r.g = s.f; r.f = s.e; r.e = s.d + t1;
      r.d = s.c; r.c = s.b; r.b = s.a; r.a = t1 + t2;
      round_step = r;
   endfunction
endpackage

[hw/rtl/sha_stream_if.sv]
// Valid/ready channel carrying one payload.
interface sha_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/sha_core.sv]
// Block compression core: 64 rounds of read then compute; 16-word schedule memory.
module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [5:0]       blk_addr,
   input  logic [7:0]       blk_data,
   input  logic             blk_we,
   input  logic             init,
   output logic             busy,
   output sha_pkg::word_type hash [8]
);
   // message_block: 16 words, byte writes
   logic [31:0] sched_mem [16];
   logic [31:0] rd_a, rd_b, rd_c, rd_d;
   logic [3:0]  ra_a, ra_b, ra_c, ra_d;
   logic [6:0]  rnd_ff, rnd_in;
   logic        busy_ff, busy_in;
   logic        ph_ff, ph_in;
   sha_pkg::work_type st_ff, st_in;
   sha_pkg::word_type hash_ff [8];
   sha_pkg::word_type w_new;
   logic [5:0]  r6;

   assign r6 = rnd_ff[5:0];
   // phase 0 issues reads for round r, phase 1 computes and writes
   always_comb begin
      ra_a = r6[3:0];
      ra_b = r6[3:0] - 4'd15;
      ra_c = r6[3:0] - 4'd2;
      ra_d = r6[3:0] - 4'd7;
   end

   always_ff @(posedge clock) begin
      rd_a <= sched_mem[ra_a];
      rd_b <= sched_mem[ra_b];
      rd_c <= sched_mem[ra_c];
      rd_d <= sched_mem[ra_d];
      if (blk_we) begin
         unique case (blk_addr[1:0])
            2'd0: sched_mem[blk_addr[5:2]][31:24] <= blk_data;
            2'd1: sched_mem[blk_addr[5:2]][23:16] <= blk_data;
            2'd2: sched_mem[blk_addr[5:2]][15:8]  <= blk_data;
            default: sched_mem[blk_addr[5:2]][7:0] <= blk_data;
         endcase
      end else if (busy_ff && ph_ff) begin
         sched_mem[ra_a] <= w_new;
      end
   end

   always_comb begin
      if (r6 < 6'd16) w_new = rd_a;
      else w_new = rd_a + sha_pkg::small_sig0(rd_b) + rd_d + sha_pkg::small_sig1(rd_c);
   end

   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      ph_in   = ph_ff;
      st_in   = st_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         rnd_in  = '0;
         ph_in   = 1'b0;
         st_in   = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                    hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
      end else if (busy_ff) begin
         ph_in = ~ph_ff;
         if (ph_ff) begin
            st_in  = sha_pkg::round_step(st_ff, sha_pkg::RoundK[r6], w_new);
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(sha_pkg::Rounds - 1)) busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= '0;
         ph_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha_pkg::InitHash[i];
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         ph_ff   <= ph_in;
         if (init) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= sha_pkg::InitHash[i];
         end else if (busy_ff && !busy_in) begin
            hash_ff[0] <= hash_ff[0] + st_in.a;
            hash_ff[1] <= hash_ff[1] + st_in.b;
            hash_ff[2] <= hash_ff[2] + st_in.c;
            hash_ff[3] <= hash_ff[3] + st_in.d;
            hash_ff[4] <= hash_ff[4] + st_in.e;
            hash_ff[5] <= hash_ff[5] + st_in.f;
            hash_ff[6] <= hash_ff[6] + st_in.g;
            hash_ff[7] <= hash_ff[7] + st_in.h;
         end
      end
      st_ff <= st_in;
   end

   assign busy = busy_ff;
   assign hash = hash_ff;
endmodule

[hw/rtl/sha256_message_hasher.sv]
// SHA-256 hasher top level: byte intake, padding sequencer, digest output.
// channel  dir  payload
// req      in   data_byte[7:0], byte_present, end_of_message
// rsp      out  digest_word[31:0], word_index[2:0], last_word
// Bytes are taken one per cycle while idle; a byte completing a block stalls req while the
// core runs 64 rounds (schedule memory read then compute/write each) and then resumes.
// An end beat pads with one byte per cycle (9 to 72 bytes, one or two blocks) save while
// a full block compresses, then offers eight rsp beats; rsp stalls hold the word in place.
// Reset is synchronous and restores the initial hash values.
module sha256_message_hasher (
   input logic clock,
   input logic reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   typedef enum logic [2:0] {S_IDLE, S_COMP, S_PAD, S_LEN, S_OUT} state_type;
   state_type   state_ff;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [2:0]  idx_ff;
   logic        fin_ff;
   logic        done_ff;
   logic        we;
   logic [7:0]  wdata;
   logic        start, init, busy;
   sha_pkg::word_type hash [8];

   sha_core u_core (
      .clock, .reset, .start, .blk_addr(fill_ff), .blk_data(wdata), .blk_we(we),
      .init, .busy, .hash
   );

   assign req.ready = (state_ff == S_IDLE);
   always_comb begin
      we = 1'b0; wdata = req.payload.data_byte;
      unique case (state_ff)
         S_IDLE: we = req.valid && req.payload.byte_present;
         S_PAD: begin we = 1'b1; wdata = (idx_ff == 3'd1) ? sha_pkg::PadByte : 8'h00; end
         S_LEN: begin we = 1'b1; wdata = bits_ff[63 - 8*idx_ff -: 8]; end
         default: we = 1'b0;
      endcase
   end
   assign start = we && (fill_ff == 6'd63);
   assign init  = (state_ff == S_OUT) && rsp.ready && (idx_ff == 3'd7);

   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload.digest_word = hash[idx_ff];
   assign rsp.payload.word_index  = idx_ff;
   assign rsp.payload.last_word   = (idx_ff == 3'd7);

   // idx_ff in PAD: 1 while first pad byte pending, 0 after
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; bits_ff <= '0; idx_ff <= '0; fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (we) fill_ff <= fill_ff + 6'd1;
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               if (req.payload.byte_present) bits_ff <= bits_ff + 64'd8;
               fin_ff <= req.payload.end_of_message;
               idx_ff <= 3'd1;
               if (start) state_ff <= S_COMP;
               else if (req.payload.end_of_message) state_ff <= S_PAD;
            end
            // after the length block go out, else resume padding or intake
            S_COMP: if (!busy && !start)
               state_ff <= done_ff ? S_OUT : (fin_ff ? S_PAD : S_IDLE);
            S_PAD: begin
               idx_ff <= 3'd0;
               if (start) begin state_ff <= S_COMP; fin_ff <= 1'b1; end
               else if (fill_ff == 6'(sha_pkg::LenPos - 1)) state_ff <= S_LEN;
            end
            S_LEN: begin
               idx_ff <= idx_ff + 3'd1;
               if (start) begin state_ff <= S_COMP; fin_ff <= 1'b0; done_ff <= 1'b1; end
            end
            S_OUT: if (rsp.ready) begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_ff <= S_IDLE; bits_ff <= '0; done_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[hw/rtl/sha_checker.sv]
// Port-level checks for the SHA-256 hasher.
`include "sha256_message_hasher_defines.svh"
module sha_checker (
   input logic clock, input logic reset,
   input logic req_valid, input logic req_ready,
   input logic rsp_valid, input logic rsp_ready,
   input logic [2:0] rsp_idx, input logic rsp_last
);
   `SHA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "req taken during digest")
   `SHA_ASSERT_IMP(a_last, clock, reset, rsp_valid, rsp_last == (rsp_idx == 3'd7), "bad last")
   `SHA_ASSERT_NEXT(a_step, clock, reset, rsp_valid && rsp_ready && !rsp_last,
      rsp_valid && rsp_idx == $past(rsp_idx) + 3'd1, "index skip")
endmodule
bind sha256_message_hasher sha_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_idx(rsp.payload.word_index), .rsp_last(rsp.payload.last_word)
);
